[rtl/cwmb_pkg.sv]
// Shared constants and types for the cross window mean blur block.
// Holds register indexes, field widths, reset values and the sequencer enums.
// No dependencies.
`timescale 1ns / 1ps

package cwmb_pkg;

	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int RAD_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int PIX_W      = 8;
	localparam int RGB_W      = 3 * PIX_W;
	localparam int QUO_W      = 8;
	localparam int N_CH       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd512;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd512;
	localparam logic [RAD_W-1:0] RADIUS_RST       = 4'd1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FLUSH,
		ST_DSTART,
		ST_DWAIT,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_DN,
		DIR_LF,
		DIR_RT
	} dir_t;

endpackage

[rtl/cwmb_ifs.sv]
// Channel interfaces: pixel input beats and blurred result beats.
// Depends on cwmb_pkg for the channel width.
`timescale 1ns / 1ps

interface cwmb_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [cwmb_pkg::PIX_W-1:0] red_in;
	logic [cwmb_pkg::PIX_W-1:0] green_in;
	logic [cwmb_pkg::PIX_W-1:0] blue_in;

	modport source (output valid, kind, red_in, green_in, blue_in, input ready);
	modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface cwmb_res_if;
	logic                       valid;
	logic                       ready;
	logic [cwmb_pkg::PIX_W-1:0] red_out;
	logic [cwmb_pkg::PIX_W-1:0] green_out;
	logic [cwmb_pkg::PIX_W-1:0] blue_out;
	logic                       frame_last;

	modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

[rtl/cross_window_mean_blur.sv]
// Top level: plus-shaped mean filter over an RGB frame in raster order.
// Uses cwmb_pkg, cwmb_ifs, cwmb_line_store and cwmb_divider.
//
//   channel  dir  handshake      payload
//   pix      in   valid/ready    kind, red_in, green_in, blue_in
//   res      out  valid/ready    red_out, green_out, blue_out, frame_last
//   cfg      in   cfg_wr_en      cfg_index, cfg_data
//
// An item that gives no result leaves the sequencer idle. An item that gives a result
// is summed from 4*radius+1 reads through the single registered read port of the line
// store, then divided in 8 steps of the divider; no new item is taken until it is loaded.
// Reset clears counters and control; the line store is not cleared.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module cross_window_mean_blur #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_RADIUS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [cwmb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cwmb_pkg::CFG_DATA_W-1:0]      cfg_data,
	cwmb_pix_if.sink                             pix,
	cwmb_res_if.source                           res
);
	import cwmb_pkg::*;

	localparam int SLOTS  = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SX_W   = SLOT_W + 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WC_W   = $clog2(MAX_WIDTH + 1);
	localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
	localparam int RC_W   = $clog2(MAX_RADIUS + 1);
	localparam int RW_W   = (HC_W > RC_W) ? HC_W : RC_W;
	localparam int CK_W   = ((COL_W > RC_W) ? COL_W : RC_W) + 1;
	localparam int TAP_W  = $clog2(4 * MAX_RADIUS + 2);
	localparam int SUM_W  = $clog2((4 * MAX_RADIUS + 1) * 255 + 1);
	localparam int FWX_W  = (FW_W > WC_W) ? FW_W : WC_W;
	localparam int FHX_W  = (FH_W > HC_W) ? FH_W : HC_W;
	localparam int RDX_W  = (RAD_W > RC_W) ? RAD_W : RC_W;
	localparam int ADDR_W = SLOT_W + COL_W;
	localparam int DEPTH  = SLOTS * (2 ** COL_W);

	// configuration
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [RAD_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			radius_q       <= RADIUS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_RADIUS:       radius_q       <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [FWX_W-1:0] fw_x;
	logic [FHX_W-1:0] fh_x;
	logic [RDX_W-1:0] rd_x;
	logic [WC_W-1:0]  w;
	logic [WC_W-1:0]  wm1;
	logic [HC_W-1:0]  h;
	logic [HC_W-1:0]  hm1;
	logic [RC_W-1:0]  rad;

	assign fw_x = FWX_W'(frame_width_q);
	assign fh_x = FHX_W'(frame_height_q);
	assign rd_x = RDX_W'(radius_q);

	always_comb begin
		if (fw_x == '0) begin
			w = WC_W'(1);
		end else if (fw_x > FWX_W'(MAX_WIDTH)) begin
			w = WC_W'(MAX_WIDTH);
		end else begin
			w = WC_W'(fw_x);
		end
		if (fh_x == '0) begin
			h = HC_W'(1);
		end else if (fh_x > FHX_W'(MAX_HEIGHT)) begin
			h = HC_W'(MAX_HEIGHT);
		end else begin
			h = HC_W'(fh_x);
		end
		if (rd_x == '0) begin
			rad = RC_W'(1);
		end else if (rd_x > RDX_W'(MAX_RADIUS)) begin
			rad = RC_W'(MAX_RADIUS);
		end else begin
			rad = RC_W'(rd_x);
		end
	end

	assign wm1 = w - 1'b1;
	assign hm1 = h - 1'b1;

	// sequencer state and handshake
	state_t state_q, state_nx;
	logic   pix_ready;
	logic   acc;
	logic   is_pix;
	logic   is_drain;
	logic   frame_in;
	logic   row_ok;
	logic   pend;
	logic   emit_go;
	logic   mem_we;
	logic   rd_issue;
	logic   tap_last;
	logic   div_start;
	logic   div_done;
	logic   res_free;
	logic   res_load;
	logic   res_valid_q;

	// frame counters
	logic [WC_W-1:0]   in_col_q, out_col_q;
	logic [HC_W-1:0]   in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [WC_W-1:0]   in_col_inc, out_col_inc;
	logic [WC_W-1:0]   wcol;
	logic [WC_W-1:0]   ocol_c;
	logic              last_c;

	assign acc      = pix.valid && pix_ready;
	assign is_pix   = pix.kind == KIND_PIXEL;
	assign is_drain = pix.kind == KIND_DRAIN;
	assign frame_in = in_row_q >= h;
	assign row_ok   = RW_W'(in_row_q) >= RW_W'(rad);
	assign pend     = out_row_q < h;
	assign emit_go  = acc && ((is_pix && !frame_in && row_ok && pend)
		|| (is_drain && frame_in && pend));
	assign mem_we   = acc && is_pix && !frame_in;

	assign in_col_inc  = in_col_q + 1'b1;
	assign out_col_inc = out_col_q + 1'b1;
	assign wcol        = (in_col_q > wm1) ? wm1 : in_col_q;
	assign ocol_c      = (out_col_q > wm1) ? wm1 : out_col_q;
	assign last_c      = (out_row_q >= hm1) && (out_col_q >= wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else begin
			if (mem_we) begin
				if (in_col_inc >= w) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= (in_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= in_col_inc;
				end
			end
			if (emit_go) begin
				if (last_c) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
				end else if (out_col_inc >= w) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + 1'b1;
					out_slot_q <= (out_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
				end else begin
					out_col_q <= out_col_inc;
				end
			end
		end
	end

	// center of the window being summed
	logic [HC_W-1:0]   cen_row_q;
	logic [HC_W-1:0]   hm1r_q;
	logic [COL_W-1:0]  cen_col_q;
	logic [SLOT_W-1:0] cen_slot_q;
	logic              last_q;

	always_ff @(posedge clk) begin
		if (emit_go) begin
			cen_row_q  <= out_row_q;
			hm1r_q     <= hm1 - out_row_q;
			cen_col_q  <= ocol_c[COL_W-1:0];
			cen_slot_q <= out_slot_q;
			last_q     <= last_c;
		end
	end

	// tap walk: center, then up/down/left/right for each arm step
	logic [RC_W-1:0] k_q;
	dir_t            dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			dir_q <= DIR_UP;
		end else if (emit_go) begin
			k_q   <= '0;
			dir_q <= DIR_UP;
		end else if (rd_issue) begin
			if (k_q == '0) begin
				k_q   <= RC_W'(1);
				dir_q <= DIR_UP;
			end else begin
				unique case (dir_q)
					DIR_UP: dir_q <= DIR_DN;
					DIR_DN: dir_q <= DIR_LF;
					DIR_LF: dir_q <= DIR_RT;
					DIR_RT: begin
						dir_q <= DIR_UP;
						k_q   <= k_q + 1'b1;
					end
					default: dir_q <= DIR_UP;
				endcase
			end
		end
	end

	assign tap_last = (k_q != '0) && (k_q == rad) && (dir_q == DIR_RT);

	logic [RW_W-1:0]   k_x, r_x, hm_x, d_up, d_dn;
	logic [SX_W-1:0]   s_x, du, dd, up_slot, dn_slot, dn_sum;
	logic [CK_W-1:0]   c_x, kc, wm1_x, lf_col, rt_sum, rt_col;
	logic [SLOT_W-1:0] rd_slot;
	logic [COL_W-1:0]  rd_col;

	always_comb begin
		k_x  = RW_W'(k_q);
		r_x  = RW_W'(cen_row_q);
		hm_x = RW_W'(hm1r_q);
		d_up = (k_x < r_x) ? k_x : r_x;
		d_dn = (k_x < hm_x) ? k_x : hm_x;

		s_x     = SX_W'(cen_slot_q);
		du      = SX_W'(d_up);
		dd      = SX_W'(d_dn);
		up_slot = (s_x >= du) ? s_x - du : s_x + SX_W'(SLOTS) - du;
		dn_sum  = s_x + dd;
		dn_slot = (dn_sum >= SX_W'(SLOTS)) ? dn_sum - SX_W'(SLOTS) : dn_sum;

		c_x    = CK_W'(cen_col_q);
		kc     = CK_W'(k_q);
		wm1_x  = CK_W'(wm1);
		lf_col = (c_x >= kc) ? c_x - kc : '0;
		rt_sum = c_x + kc;
		rt_col = (rt_sum > wm1_x) ? wm1_x : rt_sum;

		rd_slot = cen_slot_q;
		rd_col  = cen_col_q;
		if (k_q != '0) begin
			unique case (dir_q)
				DIR_UP: rd_slot = up_slot[SLOT_W-1:0];
				DIR_DN: rd_slot = dn_slot[SLOT_W-1:0];
				DIR_LF: rd_col  = lf_col[COL_W-1:0];
				DIR_RT: rd_col  = rt_col[COL_W-1:0];
				default: ;
			endcase
		end
	end

	logic [RGB_W-1:0] rdata;

	cwmb_line_store #(
		.DEPTH  (DEPTH),
		.DATA_W (RGB_W)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({in_slot_q, wcol[COL_W-1:0]}),
		.wdata ({pix.red_in, pix.green_in, pix.blue_in}),
		.re    (rd_issue),
		.raddr ({rd_slot, rd_col}),
		.rdata (rdata)
	);

	// accumulate one tap per cycle
	logic                       rd_vld_s1;
	logic [N_CH-1:0][SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			for (int i = 0; i < N_CH; i++) begin
				sum_q[i] <= sum_q[i] + SUM_W'(rdata[RGB_W-1-i*PIX_W -: PIX_W]);
			end
		end
	end

	logic [TAP_W-1:0]           divisor;
	logic [N_CH-1:0][QUO_W-1:0] quotient;

	assign divisor = TAP_W'({rad, 2'b00}) + TAP_W'(1);

	cwmb_divider #(
		.SUM_W (SUM_W),
		.DV_W  (TAP_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.dividend (sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// sequencer
	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (emit_go) state_nx = ST_READ;
			ST_READ:   if (tap_last) state_nx = ST_FLUSH;
			ST_FLUSH:  state_nx = ST_DSTART;
			ST_DSTART: state_nx = ST_DWAIT;
			ST_DWAIT:  if (div_done) state_nx = ST_RESULT;
			ST_RESULT: if (res_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		pix_ready = 1'b0;
		rd_issue  = 1'b0;
		div_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   pix_ready = 1'b1;
			ST_READ:   rd_issue  = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_RESULT: res_load  = res_free;
			default: ;
		endcase
	end

	assign pix.ready = pix_ready;

	// output register
	logic [PIX_W-1:0] res_r_q, res_g_q, res_b_q;
	logic             res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_r_q    <= quotient[0];
			res_g_q    <= quotient[1];
			res_b_q    <= quotient[2];
			res_last_q <= last_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.red_out    = res_r_q;
	assign res.green_out  = res_g_q;
	assign res.blue_out   = res_b_q;
	assign res.frame_last = res_last_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DWAIT)
		else $error("divider finished outside the wait state");

	a_slots_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_slot_q < SLOT_W'(SLOTS)) && (out_slot_q < SLOT_W'(SLOTS)))
		else $error("row slot out of range");

	a_tap_in_arm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> k_q <= rad)
		else $error("tap walk ran past the arm");

	a_read_data_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_READ) || (state_q == ST_FLUSH))
		else $error("read data outside the summing window");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result appeared without the sequencer");

endmodule

[rtl/cwmb_line_store.sv]
// Line store: one write port and one registered read port over the last rows.
// Address is {row slot, column}. No dependencies.
`timescale 1ns / 1ps

module cwmb_line_store #(
	parameter int DEPTH  = 34816,
	parameter int DATA_W = 24,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/cwmb_divider.sv]
// Restoring divider, one quotient bit per cycle for all three channels at once.
// Quotient is known to fit QUO_W bits. Depends on cwmb_pkg.
`timescale 1ns / 1ps

module cwmb_divider #(
	parameter int SUM_W = 14,
	parameter int DV_W  = 6
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [DV_W-1:0]                          divisor,
	input  logic [cwmb_pkg::N_CH-1:0][SUM_W-1:0]     dividend,
	output logic                                     done,
	output logic [cwmb_pkg::N_CH-1:0][cwmb_pkg::QUO_W-1:0] quotient
);
	import cwmb_pkg::*;

	localparam int X_W    = (SUM_W > DV_W + QUO_W) ? SUM_W : DV_W + QUO_W;
	localparam int STEP_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [X_W-1:0]    dsh_q;
	logic [X_W-1:0]    rem_q [N_CH];
	logic [QUO_W-1:0]  quo_q [N_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= X_W'(divisor) << (QUO_W - 1);
			for (int i = 0; i < N_CH; i++) begin
				rem_q[i] <= X_W'(dividend[i]);
			end
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			for (int i = 0; i < N_CH; i++) begin
				if (rem_q[i] >= dsh_q) begin
					rem_q[i] <= rem_q[i] - dsh_q;
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;

	always_comb begin
		for (int i = 0; i < N_CH; i++) begin
			quotient[i] = quo_q[i];
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (step_q != '0) |=> busy_q)
		else $error("divider stopped early");

endmodule
